[rtl/empc_pkg.sv]
package empc_pkg;

    // Field and register widths.
    localparam int SEL_W      = 3;
    localparam int ACT_W      = 3;
    localparam int POS_OUT_W  = 24;
    localparam int DUR_W      = 24;
    localparam int DEB_W      = 8;
    localparam int TIME_W     = 32;
    localparam int STEP_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DURATION = 2'd0,
        CFG_REVERSE  = 2'd1,
        CFG_DEBOUNCE = 2'd2
    } t_cfg_reg;

    // Action codes reported with each result word.
    typedef enum logic [ACT_W-1:0] {
        ACT_NONE       = 3'd0,
        ACT_SHUFFLE    = 3'd1,
        ACT_PREVIOUS   = 3'd2,
        ACT_PLAY_PAUSE = 3'd3,
        ACT_NEXT       = 3'd4,
        ACT_LIKE       = 3'd5
    } t_action;

    // Menu controls, in knob order.
    localparam logic [SEL_W-1:0] SEL_SHUFFLE    = 3'd0;
    localparam logic [SEL_W-1:0] SEL_PREVIOUS   = 3'd1;
    localparam logic [SEL_W-1:0] SEL_PLAY_PAUSE = 3'd2;
    localparam logic [SEL_W-1:0] SEL_NEXT       = 3'd3;
    localparam logic [SEL_W-1:0] SEL_LIKE       = 3'd4;

    localparam logic [SEL_W-1:0]        SEL_RESET      = SEL_PLAY_PAUSE;
    localparam logic [1:0]              PINS_IDLE      = 2'b11;
    localparam logic [DUR_W-1:0]        DURATION_RESET = 24'd222000;
    localparam logic [DEB_W-1:0]        DEBOUNCE_RESET = 8'd30;
    localparam logic signed [STEP_W-1:0] STEPS_PER_DETENT = 4'sd4;

    // Quadrature step for each {previous A, previous B, A, B}.
    typedef logic signed [1:0] t_delta;
    localparam t_delta GRAY_DELTA [16] = '{
        2'sb00, 2'sb11, 2'sb01, 2'sb00,
        2'sb01, 2'sb00, 2'sb00, 2'sb11,
        2'sb11, 2'sb00, 2'sb00, 2'sb01,
        2'sb00, 2'sb01, 2'sb11, 2'sb00
    };

    typedef struct packed {
        logic [SEL_W-1:0] selection;
        logic             moved;
    } t_knob_status;

endpackage

[rtl/empc_knob.sv]
module empc_knob #(
    parameter int NUM_CONTROLS = 5
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_advance,
    input  logic                    i_pin_a,
    input  logic                    i_pin_b,
    input  logic                    i_reverse,
    output empc_pkg::t_knob_status  o_status
);
    import empc_pkg::*;

    localparam logic [SEL_W-1:0] SEL_LAST = SEL_W'(NUM_CONTROLS - 1);

    logic [1:0]               r_prev_pins;
    logic signed [STEP_W-1:0] r_step_count;
    logic signed [STEP_W-1:0] n_step_count;
    logic [SEL_W-1:0]         r_selection;
    logic [SEL_W-1:0]         n_selection;
    logic [1:0]               pins;
    t_delta                   delta;
    logic signed [STEP_W-1:0] step_sum;
    logic                     detent_up;
    logic                     detent_down;
    logic [SEL_W-1:0]         sel_up;
    logic [SEL_W-1:0]         sel_down;
    logic [SEL_W-1:0]         sel_minus;

    always_comb begin
        pins        = {i_pin_a, i_pin_b};
        delta       = GRAY_DELTA[{r_prev_pins, pins}];
        step_sum    = r_step_count + {{(STEP_W-2){delta[1]}}, delta};
        detent_up   = (step_sum >= STEPS_PER_DETENT);
        detent_down = (step_sum <= -STEPS_PER_DETENT);

        // Clamped neighbours of the current selection.
        sel_up    = (r_selection >= SEL_LAST) ? SEL_LAST : r_selection + SEL_W'(1);
        sel_minus = r_selection - SEL_W'(1);
        if (r_selection == '0) begin
            sel_down = '0;
        end else if (sel_minus > SEL_LAST) begin
            sel_down = SEL_LAST;
        end else begin
            sel_down = sel_minus;
        end

        n_step_count = step_sum;
        n_selection  = r_selection;
        if (detent_up || detent_down) begin
            n_step_count = '0;
            n_selection  = (detent_up ^ i_reverse) ? sel_up : sel_down;
        end

        o_status.selection = n_selection;
        o_status.moved     = (n_selection != r_selection);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pins  <= PINS_IDLE;
            r_step_count <= '0;
            r_selection  <= SEL_RESET;
        end else if (i_advance) begin
            r_prev_pins  <= pins;
            r_step_count <= n_step_count;
            r_selection  <= n_selection;
        end
    end

endmodule

[rtl/encoder_menu_playback_controller_unit.sv]
// Rotary-knob menu controller for a media playback panel. Each input word carries the two
// sampled encoder pins, a button rising-edge flag and the free-running millisecond time; each
// input word yields exactly one result word with the selected control, whether it moved, the
// action taken, the shuffle, like and playing flags, and the play position at that time. The
// block takes one word per clock while it does not stall its input. The word is captured in
// an input register, decoded by one pass of logic (quadrature step, detent, debounced press,
// position adder and saturation) and captured in the result register, which also serves as
// the output stage so that a new word is accepted while a result is waiting.
// Configuration writes must only be made while no word is in flight.
module encoder_menu_playback_controller_unit #(
    parameter int NUM_CONTROLS  = 5,
    parameter int POSITION_BITS = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [empc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [empc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_pin_a,
    input  logic                             i_pin_b,
    input  logic                             i_button_edge,
    input  logic [empc_pkg::TIME_W-1:0]      i_now_ms,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [empc_pkg::SEL_W-1:0]       o_selected_control,
    output logic                             o_selection_moved,
    output logic [empc_pkg::ACT_W-1:0]       o_action,
    output logic                             o_shuffle_on,
    output logic                             o_liked_on,
    output logic                             o_playing_on,
    output logic [empc_pkg::POS_OUT_W-1:0]   o_position_ms
);
    import empc_pkg::*;

    // The position sum is kept one bit wider than the time so that it never wraps.
    localparam int                SUM_W       = TIME_W + 1;
    localparam logic [SUM_W-1:0]  POS_MAX     = (SUM_W'(1) << POSITION_BITS) - SUM_W'(1);
    localparam logic [SUM_W-1:0]  RESET_LIMIT = (SUM_W'(DURATION_RESET) > POS_MAX) ?
                                                POS_MAX : SUM_W'(DURATION_RESET);

    // Configuration. The duration is held already clamped to the position range.
    logic [POSITION_BITS-1:0] r_limit;
    logic                     r_reverse;
    logic [DEB_W-1:0]         r_debounce;

    // Handshake control.
    logic r_in_valid;
    logic r_out_valid;
    logic out_free;
    logic fire;
    logic in_accept;

    // Input register.
    logic              r_pin_a;
    logic              r_pin_b;
    logic              r_button_edge;
    logic [TIME_W-1:0] r_now_ms;

    // Playback state.
    logic                     r_shuffle;
    logic                     r_like;
    logic                     r_playing;
    logic [POSITION_BITS-1:0] r_frozen;
    logic [TIME_W-1:0]        r_resume_time;
    logic [TIME_W-1:0]        r_last_press;

    logic                     n_shuffle;
    logic                     n_like;
    logic                     n_playing;
    logic [POSITION_BITS-1:0] n_frozen;
    logic [TIME_W-1:0]        n_resume_time;
    logic [TIME_W-1:0]        n_last_press;
    t_action                  n_action;
    logic [POSITION_BITS-1:0] n_position;

    // Result register.
    logic [SEL_W-1:0]         r_selected;
    logic                     r_moved;
    t_action                  r_action;
    logic                     r_shuffle_out;
    logic                     r_like_out;
    logic                     r_playing_out;
    logic [POSITION_BITS-1:0] r_position;

    t_knob_status             knob;
    logic                     press;
    logic                     pausing;
    logic                     resuming;
    logic [TIME_W-1:0]        elapsed;
    logic [SUM_W-1:0]         pos_sum;
    logic [POSITION_BITS-1:0] pos_sat;

    // A word moves from the input register to the result register whenever the result
    // register is empty or its word is being taken in the same cycle.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    // The encoder is decoded first, so that a press acts on the selection it leaves.
    empc_knob #(
        .NUM_CONTROLS (NUM_CONTROLS)
    ) u_knob (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (fire),
        .i_pin_a   (r_pin_a),
        .i_pin_b   (r_pin_b),
        .i_reverse (r_reverse),
        .o_status  (knob)
    );

    always_comb begin
        // A press is taken only once strictly more than the debounce time has passed since
        // the last accepted press; a rejected edge is simply dropped.
        press   = r_button_edge && ((r_now_ms - r_last_press) > TIME_W'(r_debounce));
        elapsed = r_now_ms - r_resume_time;

        n_shuffle     = r_shuffle;
        n_like        = r_like;
        n_playing     = r_playing;
        n_resume_time = r_resume_time;
        n_last_press  = r_last_press;
        n_action      = ACT_NONE;
        pausing       = 1'b0;
        resuming      = 1'b0;

        if (press) begin
            n_last_press = r_now_ms;
            unique case (knob.selection)
                SEL_SHUFFLE: begin
                    n_shuffle = !r_shuffle;
                    n_action  = ACT_SHUFFLE;
                end
                SEL_PREVIOUS: begin
                    n_action = ACT_PREVIOUS;
                end
                SEL_PLAY_PAUSE: begin
                    pausing  = r_playing;
                    resuming = !r_playing;
                    n_action = ACT_PLAY_PAUSE;
                end
                SEL_NEXT: begin
                    n_action = ACT_NEXT;
                end
                SEL_LIKE: begin
                    n_like   = !r_like;
                    n_action = ACT_LIKE;
                end
                default: begin
                    // Controls beyond the like button carry no meaning.
                end
            endcase
        end

        // One adder serves every case: on resume the elapsed time is zero, since the
        // resume time is being set to now.
        pos_sum = SUM_W'(r_frozen) + SUM_W'(resuming ? '0 : elapsed);
        pos_sat = (pos_sum > SUM_W'(r_limit)) ? r_limit : POSITION_BITS'(pos_sum);

        n_frozen = r_frozen;
        if (pausing) begin
            n_frozen  = pos_sat;
            n_playing = 1'b0;
        end
        if (resuming) begin
            n_resume_time = r_now_ms;
            n_playing     = 1'b1;
        end

        // While paused the stored position is reported as it stands, even if the duration
        // has since been lowered below it.
        n_position = n_playing ? pos_sat : n_frozen;
    end

    // Control, configuration and playback state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit       <= POSITION_BITS'(RESET_LIMIT);
            r_reverse     <= 1'b0;
            r_debounce    <= DEBOUNCE_RESET;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_shuffle     <= 1'b0;
            r_like        <= 1'b0;
            r_playing     <= 1'b1;
            r_frozen      <= '0;
            r_resume_time <= '0;
            r_last_press  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_DURATION: begin
                        r_limit <= (SUM_W'(i_cfg_data[DUR_W-1:0]) > POS_MAX) ?
                                   POSITION_BITS'(POS_MAX) :
                                   POSITION_BITS'(i_cfg_data[DUR_W-1:0]);
                    end
                    CFG_REVERSE: begin
                        r_reverse <= i_cfg_data[0];
                    end
                    CFG_DEBOUNCE: begin
                        r_debounce <= i_cfg_data[DEB_W-1:0];
                    end
                    default: begin
                        // Writes to unused indexes are ignored.
                    end
                endcase
            end

            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end

            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (fire) begin
                r_shuffle     <= n_shuffle;
                r_like        <= n_like;
                r_playing     <= n_playing;
                r_frozen      <= n_frozen;
                r_resume_time <= n_resume_time;
                r_last_press  <= n_last_press;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pin_a       <= i_pin_a;
            r_pin_b       <= i_pin_b;
            r_button_edge <= i_button_edge;
            r_now_ms      <= i_now_ms;
        end
        if (fire) begin
            r_selected    <= knob.selection;
            r_moved       <= knob.moved;
            r_action      <= n_action;
            r_shuffle_out <= n_shuffle;
            r_like_out    <= n_like;
            r_playing_out <= n_playing;
            r_position    <= n_position;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_selected_control = r_selected;
    assign o_selection_moved  = r_moved;
    assign o_action           = r_action;
    assign o_shuffle_on       = r_shuffle_out;
    assign o_liked_on         = r_like_out;
    assign o_playing_on       = r_playing_out;
    assign o_position_ms      = POS_OUT_W'(r_position);

endmodule

[dv/encoder_menu_checker.sv]
module encoder_menu_checker #(
    parameter int NUM_CONTROLS = 5
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [empc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [empc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic                             i_pin_a,
    input  logic                             i_pin_b,
    input  logic                             i_button_edge,
    input  logic [empc_pkg::TIME_W-1:0]      i_now_ms,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic [empc_pkg::SEL_W-1:0]       i_selected_control,
    input  logic                             i_selection_moved,
    input  logic [empc_pkg::ACT_W-1:0]       i_action,
    input  logic                             i_shuffle_on,
    input  logic                             i_liked_on,
    input  logic                             i_playing_on,
    input  logic [empc_pkg::POS_OUT_W-1:0]   i_position_ms,
    output int                               o_fail_count,
    output int                               o_words_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import empc_pkg::*;

    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [SEL_W-1:0]     control;
        logic                 moved;
        t_action              action;
        logic                 shuffle;
        logic                 liked;
        logic                 playing;
        logic [POS_OUT_W-1:0] position;
    } t_panel_word;

    // Settings and menu state as the block should hold them.
    logic [DUR_W-1:0]     duration_ms;
    logic                 knob_reversed;
    logic [DEB_W-1:0]     debounce_limit;
    logic [1:0]           knob_last;
    int                   detent_steps;
    logic [SEL_W-1:0]     menu_sel;
    logic                 shuffle_st;
    logic                 like_st;
    logic                 playing_st;
    logic [POS_OUT_W-1:0] held_position;
    logic [TIME_W-1:0]    resume_ms;
    logic [TIME_W-1:0]    press_ms;

    t_panel_word panel_words_due[$];
    t_panel_word want;
    int          fail_count = 0;
    int          words_checked = 0;
    int          words_due = 0;

    assign o_fail_count    = fail_count;
    assign o_words_pending = words_due;

    task automatic report_mismatch(input string line);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%s", line);
        end
    endtask

    function automatic int quad_step(input logic [1:0] from, input logic [1:0] to);
        case ({from, to})
            4'b0001, 4'b0111, 4'b1000, 4'b1110: return -1;
            4'b0010, 4'b0100, 4'b1011, 4'b1101: return 1;
            default: return 0;
        endcase
    endfunction

    // Frozen position plus elapsed time while playing, without wrapping, clipped at the duration.
    function automatic logic [POS_OUT_W-1:0] play_position(input logic [TIME_W-1:0] now);
        logic [TIME_W:0] sum;
        if (!playing_st) begin
            return held_position;
        end
        sum = {{(TIME_W + 1 - POS_OUT_W){1'b0}}, held_position} + {1'b0, now - resume_ms};
        if (sum > {{(TIME_W + 1 - DUR_W){1'b0}}, duration_ms}) begin
            sum = {{(TIME_W + 1 - DUR_W){1'b0}}, duration_ms};
        end
        return sum[POS_OUT_W-1:0];
    endfunction

    // The knob is handled first, so that a press acts on the selection it leaves.
    function automatic t_panel_word step_menu(input logic a, input logic b, input logic press,
                                              input logic [TIME_W-1:0] now);
        t_panel_word      res;
        int               turn;
        int               target;
        logic [TIME_W-1:0] since;
        res = '0;
        res.action = ACT_NONE;
        turn = 0;
        detent_steps += quad_step(knob_last, {a, b});
        knob_last = {a, b};
        if (detent_steps >= 4) begin
            detent_steps = 0;
            turn = knob_reversed ? -1 : 1;
        end else if (detent_steps <= -4) begin
            detent_steps = 0;
            turn = knob_reversed ? 1 : -1;
        end
        if (turn != 0) begin
            target = int'(menu_sel) + turn;
            if (target < 0) target = 0;
            if (target > NUM_CONTROLS - 1) target = NUM_CONTROLS - 1;
            if (target != int'(menu_sel)) begin
                menu_sel = 3'(target);
                res.moved = 1'b1;
            end
        end
        since = now - press_ms;
        if (press && since > TIME_W'(debounce_limit)) begin
            press_ms = now;
            case (menu_sel)
                SEL_SHUFFLE: begin
                    shuffle_st = ~shuffle_st;
                    res.action = ACT_SHUFFLE;
                end
                SEL_PREVIOUS: res.action = ACT_PREVIOUS;
                SEL_PLAY_PAUSE: begin
                    if (playing_st) begin
                        held_position = play_position(now);
                        playing_st = 1'b0;
                    end else begin
                        resume_ms = now;
                        playing_st = 1'b1;
                    end
                    res.action = ACT_PLAY_PAUSE;
                end
                SEL_NEXT: res.action = ACT_NEXT;
                SEL_LIKE: begin
                    like_st = ~like_st;
                    res.action = ACT_LIKE;
                end
                default: res.action = ACT_NONE;
            endcase
        end
        res.control  = menu_sel;
        res.shuffle  = shuffle_st;
        res.liked    = like_st;
        res.playing  = playing_st;
        res.position = play_position(now);
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            duration_ms    = DURATION_RESET;
            knob_reversed  = 1'b0;
            debounce_limit = DEBOUNCE_RESET;
            knob_last      = PINS_IDLE;
            detent_steps   = 0;
            menu_sel       = SEL_RESET;
            shuffle_st     = 1'b0;
            like_st        = 1'b0;
            playing_st     = 1'b1;
            held_position  = '0;
            resume_ms      = '0;
            press_ms       = '0;
            panel_words_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DURATION: duration_ms    = i_cfg_data[DUR_W-1:0];
                    CFG_REVERSE:  knob_reversed  = i_cfg_data[0];
                    CFG_DEBOUNCE: debounce_limit = i_cfg_data[DEB_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (panel_words_due.size() == 0) begin
                    report_mismatch($sformatf("word %0d: result with nothing expected",
                                              words_checked));
                end else begin
                    want = panel_words_due.pop_front();
                    if (i_selected_control !== want.control)
                        report_mismatch($sformatf("word %0d selected_control: got %0d, exp %0d",
                                                  words_checked, i_selected_control,
                                                  want.control));
                    if (i_selection_moved !== want.moved)
                        report_mismatch($sformatf("word %0d selection_moved: got %0d, exp %0d",
                                                  words_checked, i_selection_moved, want.moved));
                    if (i_action !== want.action)
                        report_mismatch($sformatf("word %0d action: got %0d, exp %0d",
                                                  words_checked, i_action, want.action));
                    if (i_shuffle_on !== want.shuffle)
                        report_mismatch($sformatf("word %0d shuffle_on: got %0d, exp %0d",
                                                  words_checked, i_shuffle_on, want.shuffle));
                    if (i_liked_on !== want.liked)
                        report_mismatch($sformatf("word %0d liked_on: got %0d, exp %0d",
                                                  words_checked, i_liked_on, want.liked));
                    if (i_playing_on !== want.playing)
                        report_mismatch($sformatf("word %0d playing_on: got %0d, exp %0d",
                                                  words_checked, i_playing_on, want.playing));
                    if (i_position_ms !== want.position)
                        report_mismatch($sformatf("word %0d position_ms: got %0d, exp %0d",
                                                  words_checked, i_position_ms, want.position));
                end
                words_checked++;
            end
            if (i_in_valid && !i_in_stall) begin
                panel_words_due.push_back(step_menu(i_pin_a, i_pin_b, i_button_edge, i_now_ms));
            end
        end
        words_due = panel_words_due.size();
    end

endmodule

[dv/encoder_menu_playback_controller_unit_tb.sv]
module encoder_menu_playback_controller_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import empc_pkg::*;

    // A word taken passes through the input register and the result register
    // before it is on the result port.
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_HOLD     = 200;
    localparam int CYCLE_LIMIT   = 400000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    t_cfg_reg              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  pin_a;
    logic                  pin_b;
    logic                  button_edge;
    logic [TIME_W-1:0]     now_ms;
    logic                  out_valid;
    logic                  out_stall;
    logic [SEL_W-1:0]      selected_control;
    logic                  selection_moved;
    logic [ACT_W-1:0]      action;
    logic                  shuffle_on;
    logic                  liked_on;
    logic                  playing_on;
    logic [POS_OUT_W-1:0]  position_ms;

    int fail_count;
    int words_pending;
    int cycle_count;

    // Stimulus side: the knob's present pin levels, the millisecond clock
    // as last sent, and how many words the block has taken so far.
    logic [1:0]        knob;
    logic [TIME_W-1:0] clock_ms;
    int                words_sent;

    // Raised once by the stimulus; the receiver answers with one long hold-off.
    logic hold_off_req = 1'b0;

    encoder_menu_playback_controller_unit i_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_pin_a            (pin_a),
        .i_pin_b            (pin_b),
        .i_button_edge      (button_edge),
        .i_now_ms           (now_ms),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_selected_control (selected_control),
        .o_selection_moved  (selection_moved),
        .o_action           (action),
        .o_shuffle_on       (shuffle_on),
        .o_liked_on         (liked_on),
        .o_playing_on       (playing_on),
        .o_position_ms      (position_ms)
    );

    encoder_menu_checker i_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .i_in_stall         (in_stall),
        .i_pin_a            (pin_a),
        .i_pin_b            (pin_b),
        .i_button_edge      (button_edge),
        .i_now_ms           (now_ms),
        .i_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .i_selected_control (selected_control),
        .i_selection_moved  (selection_moved),
        .i_action           (action),
        .i_shuffle_on       (shuffle_on),
        .i_liked_on         (liked_on),
        .i_playing_on       (playing_on),
        .i_position_ms      (position_ms),
        .o_fail_count       (fail_count),
        .o_words_pending    (words_pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offers one word, after a random gap, and returns at the edge that takes it.
    // The valid line is only lowered for a gap, so back-to-back words keep it high
    // and the payload never moves while the block is stalling.
    task automatic send_word(input logic a, input logic b, input logic press,
                             input logic [TIME_W-1:0] ms);
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            gap = 0;
        end else if (pick < 90) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(8, 30);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        pin_a       <= a;
        pin_b       <= b;
        button_edge <= press;
        now_ms      <= ms;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent++;
    endtask

    // Walks the pins along the Gray sequence, one step per word. Four steps in
    // one direction make a detent; fewer leave a part-count behind in the block.
    task automatic turn_knob(input bit cw, input int steps, input bit press_last);
        for (int k = 0; k < steps; k++) begin
            if (cw) begin
                case (knob)
                    2'b11:   knob = 2'b01;
                    2'b01:   knob = 2'b00;
                    2'b00:   knob = 2'b10;
                    default: knob = 2'b11;
                endcase
            end else begin
                case (knob)
                    2'b11:   knob = 2'b10;
                    2'b10:   knob = 2'b00;
                    2'b00:   knob = 2'b01;
                    default: knob = 2'b11;
                endcase
            end
            clock_ms += $urandom_range(0, 40);
            send_word(knob[1], knob[0], press_last && (k == steps - 1), clock_ms);
        end
    endtask

    // Mostly short steps so that the debounce window matters, sometimes long
    // ones to run the position into saturation, and now and then a jump to an
    // arbitrary time, which also lets the clock go backwards or wrap.
    function automatic void advance_clock();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            clock_ms += $urandom_range(0, 40);
        end else if (pick < 80) begin
            clock_ms += $urandom_range(41, 400);
        end else if (pick < 95) begin
            clock_ms += $urandom_range(401, 200000);
        end else begin
            clock_ms = $urandom;
        end
    endfunction

    // Registers are only written with nothing in flight. The write enable is
    // held across the three back-to-back writes and dropped after the last.
    task automatic load_settings(input logic [DUR_W-1:0] dur, input logic rev,
                                 input logic [DEB_W-1:0] deb);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DURATION;
        cfg_data  <= CFG_DATA_W'(dur);
        @(posedge clk);
        cfg_index <= CFG_REVERSE;
        cfg_data  <= CFG_DATA_W'(rev);
        @(posedge clk);
        cfg_index <= CFG_DEBOUNCE;
        cfg_data  <= CFG_DATA_W'(deb);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Stops offering and waits for every expected result word. The count is
    // looked at on the falling edge, well clear of the checker's update.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (words_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Most of the traffic is clean detents with random direction, length and
    // press, so the selection wanders over the whole menu and hits both ends.
    // The rest is plain presses, idle polls and noise with arbitrary pins.
    task automatic random_phase(input int words);
        int stop_at;
        int pick;
        stop_at = words_sent + words;
        while (words_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                turn_knob(1'($urandom_range(0, 1)),
                          ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 4,
                          1'($urandom_range(0, 1)));
            end else if (pick < 80) begin
                advance_clock();
                send_word(knob[1], knob[0], 1'b1, clock_ms);
            end else if (pick < 90) begin
                advance_clock();
                send_word(knob[1], knob[0], 1'b0, clock_ms);
            end else begin
                knob = 2'($urandom_range(0, 3));
                if ($urandom_range(0, 1)) begin
                    clock_ms = $urandom;
                end else begin
                    advance_clock();
                end
                send_word(knob[1], knob[0], 1'($urandom_range(0, 1)), clock_ms);
            end
        end
    endtask

    // The receiver stalls at random: long clear runs, short stalls and a few
    // longer ones. When asked, it holds off for a long stretch so that the
    // block fills up and stalls its input while words are still on offer.
    initial begin : receiver
        int  run_cycles;
        int  pick;
        bit  held;
        held = 1'b0;
        forever begin
            pick = $urandom_range(0, 99);
            if (hold_off_req && !held) begin
                held       = 1'b1;
                out_stall <= 1'b1;
                run_cycles = LONG_HOLD;
            end else if (pick < 50) begin
                out_stall <= 1'b0;
                run_cycles = $urandom_range(1, 30);
            end else if (pick < 90) begin
                out_stall <= 1'b1;
                run_cycles = $urandom_range(1, 3);
            end else begin
                out_stall <= 1'b1;
                run_cycles = $urandom_range(10, 40);
            end
            repeat (run_cycles) @(posedge clk);
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= CFG_DURATION;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        pin_a       <= 1'b1;
        pin_b       <= 1'b1;
        button_edge <= 1'b0;
        now_ms      <= '0;
        knob        = PINS_IDLE;
        clock_ms    = '0;
        words_sent  = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, on the reset settings. A press exactly at the debounce
        // limit is dropped and one a millisecond later pauses playback.
        send_word(1'b1, 1'b1, 1'b0, 32'd0);
        send_word(1'b1, 1'b1, 1'b1, 32'd30);
        send_word(1'b1, 1'b1, 1'b1, 32'd31);
        send_word(1'b1, 1'b1, 1'b1, 32'd40);
        // While paused the position stays frozen however much time goes by.
        send_word(1'b1, 1'b1, 1'b0, 32'd5000);
        // Resume at the top of the time range, then let the clock wrap.
        send_word(1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
        send_word(1'b1, 1'b1, 1'b0, 32'h0000_0010);
        // Both pins jumping at once is not a valid step and counts nothing.
        send_word(1'b0, 1'b0, 1'b0, 32'd20);
        send_word(1'b1, 1'b1, 1'b0, 32'd21);
        // Turn back to previous, then to shuffle, then push against the low end.
        clock_ms = 32'd1000;
        turn_knob(1'b0, 4, 1'b1);
        clock_ms += 1000;
        turn_knob(1'b0, 4, 1'b1);
        turn_knob(1'b0, 4, 1'b0);
        // A huge jump in time runs the position into the duration.
        clock_ms = 32'h7FFF_FFFF;
        send_word(knob[1], knob[0], 1'b0, clock_ms);
        drain_results();

        // Widest duration, reversed knob, no debounce. The long receiver
        // hold-off falls at the start of this phase.
        load_settings({DUR_W{1'b1}}, 1'b1, '0);
        hold_off_req <= 1'b1;
        random_phase(160);
        drain_results();

        // Zero duration pins the position at zero; the longest debounce.
        load_settings('0, 1'b0, {DEB_W{1'b1}});
        random_phase(160);
        drain_results();

        load_settings(DUR_W'($urandom_range(1000, 400000)), 1'($urandom_range(0, 1)),
                      DEB_W'($urandom_range(1, 254)));
        random_phase(160);
        drain_results();

        // A short track, so that saturation and pausing past the end are common.
        load_settings(DUR_W'(5000), 1'b1, DEBOUNCE_RESET);
        random_phase(170);
        drain_results();

        if (fail_count == 0 && words_pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[files.f]
rtl/empc_pkg.sv
rtl/empc_knob.sv
rtl/encoder_menu_playback_controller_unit.sv
dv/encoder_menu_checker.sv
dv/encoder_menu_playback_controller_unit_tb.sv
